// File: rtl/dq_pkg.sv
// Package for the double-ended queue: operation codes, status codes and the
// response flags passed from the pointer control to the result stage.
// No dependencies.
package dq_pkg;

	localparam int WORD_W = 32;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_READ_FRONT = 3'd4;
	localparam logic [2:0] OP_READ_BACK  = 3'd5;
	localparam logic [2:0] OP_STATUS     = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0] status;
		logic       has_data;
	} dq_resp_t;

endpackage

// File: rtl/dq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/dq_ctrl.sv
// Head pointer and entry count of the deque, and the memory access for each
// operation. Depends on dq_pkg.
module dq_ctrl import dq_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [2:0]                 operation,
	input  logic signed [WORD_W-1:0]   push_value,
	output logic                       mem_we,
	output logic [$clog2(DEPTH)-1:0]   mem_waddr,
	output logic [WORD_W-1:0]          mem_wdata,
	output logic                       mem_re,
	output logic [$clog2(DEPTH)-1:0]   mem_raddr,
	output dq_resp_t                   resp,
	output logic [$clog2(DEPTH+1)-1:0] count_next
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_next;
	logic [CW-1:0] count_d;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [SW-1:0] tail_sum;
	logic [SW-1:0] back_sum;
	logic [AW-1:0] tail_idx;
	logic [AW-1:0] back_idx;
	logic          full;
	logic          empty;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

	// Head plus count stays below twice the depth, so one subtract wraps it.
	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign back_sum = tail_sum - 1'b1;
	assign tail_idx = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
	assign back_idx = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

	always_comb begin
		head_next     = head_q;
		count_d       = count_q;
		mem_we        = 1'b0;
		mem_waddr     = head_dec;
		mem_wdata     = push_value;
		mem_re        = 1'b0;
		mem_raddr     = head_q;
		resp.status   = ST_OK;
		resp.has_data = 1'b0;
		unique case (operation)
			OP_PUSH_FRONT: begin
				if (full) begin
					resp.status = ST_FULL;
				end else begin
					head_next = head_dec;
					count_d   = count_q + 1'b1;
					mem_we    = accept;
				end
			end
			OP_PUSH_BACK: begin
				mem_waddr = tail_idx;
				if (full) begin
					resp.status = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
					mem_we  = accept;
				end
			end
			OP_POP_FRONT, OP_READ_FRONT: begin
				if (empty) begin
					resp.status = ST_EMPTY;
				end else begin
					resp.has_data = 1'b1;
					mem_re        = accept;
					if (operation == OP_POP_FRONT) begin
						head_next = head_inc;
						count_d   = count_q - 1'b1;
					end
				end
			end
			OP_POP_BACK, OP_READ_BACK: begin
				mem_raddr = back_idx;
				if (empty) begin
					resp.status = ST_EMPTY;
				end else begin
					resp.has_data = 1'b1;
					mem_re        = accept;
					if (operation == OP_POP_BACK) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			default: begin
				// Status query and the unused code leave the state alone.
			end
		endcase
	end

	assign count_next = count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_next;
			count_q <= count_d;
		end
	end

endmodule

// File: rtl/double_ended_queue_top.sv
// Double-ended queue of signed 32-bit words stored in a circular RAM of
// DEPTH entries. Depends on dq_pkg, dq_ctrl and dq_ram.
//
// The deque takes one operation per clock cycle while out_stall is low; each
// operation returns exactly one result word, through the synchronous RAM
// read and then the output register. The head pointer and count update at
// acceptance, so back-to-back operations see each other's effects. A push
// into a full deque is refused with status full, and a pop or read of an
// empty deque returns status empty and zero data. The RAM contents need no
// clearing after reset.
module double_ended_queue_top import dq_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 operation,
	input  logic signed [WORD_W-1:0]   push_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [WORD_W-1:0]   data_word,
	output logic [1:0]                 status,
	output logic [$clog2(DEPTH+1)-1:0] entry_count,
	output logic                       is_empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic              accept;
	logic              advance;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [WORD_W-1:0] mem_rdata;
	dq_resp_t          resp;
	logic [CW-1:0]     count_next;

	logic              valid_s1;
	dq_resp_t          resp_s1;
	logic [CW-1:0]     count_s1;

	logic              out_valid_q;
	logic [WORD_W-1:0] data_q;
	logic [1:0]        status_q;
	logic [CW-1:0]     count_q;
	logic              empty_q;

	// The first stage moves on when the output register is free or being taken.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	dq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (operation),
		.push_value (push_value),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.resp       (resp),
		.count_next (count_next)
	);

	dq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			resp_s1  <= resp;
			count_s1 <= count_next;
		end
		if (advance && valid_s1) begin
			data_q   <= resp_s1.has_data ? mem_rdata : '0;
			status_q <= resp_s1.status;
			count_q  <= count_s1;
			empty_q  <= (count_s1 == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign data_word   = data_q;
	assign status      = status_q;
	assign entry_count = count_q;
	assign is_empty    = empty_q;

endmodule

// File: dv/tb.sv
// Self-checking testbench for double_ended_queue_top: directed and random deque operations
// checked against a cycle-free deque predictor kept in the testbench.
// Depends on dq_pkg and the RTL of double_ended_queue_top.
`timescale 1ns / 1ps

module tb;
	import dq_pkg::*;

	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int STALL_HOLD = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TARGET_OPS = 1850;

	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] value;
		int                 gap;
	} deque_op_t;

	typedef struct {
		logic signed [31:0] word;
		logic [1:0]         stat;
		logic [CNT_W-1:0]   count;
		logic               empty;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] operation = OP_STATUS;
	logic signed [31:0] push_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] data_word;
	logic [1:0] status;
	logic [CNT_W-1:0] entry_count;
	logic is_empty;

	deque_op_t pending_ops[$];
	deque_result_t expected_results[$];

	// Predictor state: circular store, front pointer and fill level.
	logic signed [31:0] model_words[DEPTH];
	logic [5:0] model_head = '0;
	logic [CNT_W-1:0] model_count = '0;

	int gen_count = 0;
	bit gen_burst = 1'b0;
	int gap_count = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit out_burst = 1'b0;
	int results_taken = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;

	double_ended_queue_top #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_word(data_word),
		.status(status),
		.entry_count(entry_count),
		.is_empty(is_empty)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void predict_result(input logic [2:0] op, input logic signed [31:0] value);
		deque_result_t r;
		logic [5:0] slot;
		r.word = '0;
		r.stat = ST_OK;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (model_count == DEPTH) begin
					r.stat = ST_FULL;
				end else if (op == OP_PUSH_FRONT) begin
					model_head = model_head - 6'd1;
					model_words[model_head] = value;
					model_count = model_count + 1'b1;
				end else begin
					slot = model_head + model_count[5:0];
					model_words[slot] = value;
					model_count = model_count + 1'b1;
				end
			end
			OP_POP_FRONT, OP_READ_FRONT: begin
				if (model_count == 0) begin
					r.stat = ST_EMPTY;
				end else begin
					r.word = model_words[model_head];
					if (op == OP_POP_FRONT) begin
						model_head = model_head + 6'd1;
						model_count = model_count - 1'b1;
					end
				end
			end
			OP_POP_BACK, OP_READ_BACK: begin
				if (model_count == 0) begin
					r.stat = ST_EMPTY;
				end else begin
					slot = model_head + model_count[5:0] - 6'd1;
					r.word = model_words[slot];
					if (op == OP_POP_BACK)
						model_count = model_count - 1'b1;
				end
			end
			default: begin
				// Status query and the unused code leave the deque alone.
			end
		endcase
		r.count = model_count;
		r.empty = (model_count == 0);
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void add_op(input logic [2:0] op, input logic signed [31:0] value);
		deque_op_t item;
		item.op = op;
		item.value = value;
		item.gap = gen_burst ? 0 : $urandom_range(0, 15);
		pending_ops.insert(pending_ops.size(), item);
		if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_count < DEPTH)
			gen_count++;
		else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && gen_count > 0)
			gen_count--;
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Driver: presents one operation word at a time, honoring each word's idle gap.
	always @(posedge clk or negedge arst_n) begin
		deque_op_t next_op;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= OP_STATUS;
			push_value <= '0;
			gap_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_result(operation, push_value);
			if (!in_valid || !in_stall) begin
				if (pending_ops.size() == 0) begin
					in_valid <= 1'b0;
				end else if (gap_count < pending_ops[0].gap) begin
					in_valid <= 1'b0;
					gap_count <= gap_count + 1;
				end else begin
					next_op = pending_ops[0];
					pending_ops.delete(0);
					in_valid <= 1'b1;
					operation <= next_op.op;
					push_value <= next_op.value;
					gap_count <= 0;
				end
			end
		end
	end

	// Monitor and receiver: checks each result word, then decides how long to stall.
	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result word with nothing expected: data %0d status %0d count %0d",
						$time, data_word, status, entry_count);
					mismatch_count++;
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					if (data_word !== want.word) begin
						$display("%0t: data_word expected %0d actual %0d", $time, want.word, data_word);
						mismatch_count++;
					end
					if (status !== want.stat) begin
						$display("%0t: status expected %0d actual %0d", $time, want.stat, status);
						mismatch_count++;
					end
					if (entry_count !== want.count) begin
						$display("%0t: entry_count expected %0d actual %0d",
							$time, want.count, entry_count);
						mismatch_count++;
					end
					if (is_empty !== want.empty) begin
						$display("%0t: is_empty expected %0d actual %0d", $time, want.empty, is_empty);
						mismatch_count++;
					end
				end
				results_taken++;
				if (results_taken % 50 == 0)
					out_burst = ($urandom_range(0, 3) == 0);
				// Long hold-off so that the deque backs up and stalls its input.
				if (results_taken == 400 || results_taken == 1300)
					hold_left = STALL_HOLD;
				stall_left = out_burst ? 0 : $urandom_range(0, 15);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		int n;
		bit first_segment;
		// Directed: empty cases, extreme values, every code, wrap of the front pointer.
		add_op(OP_STATUS, $urandom);
		add_op(OP_POP_FRONT, $urandom);
		add_op(OP_POP_BACK, $urandom);
		add_op(OP_READ_FRONT, $urandom);
		add_op(OP_READ_BACK, $urandom);
		add_op(OP_PUSH_FRONT, 32'sh7fffffff);
		add_op(OP_PUSH_BACK, 32'sh80000000);
		add_op(OP_READ_FRONT, $urandom);
		add_op(OP_READ_BACK, $urandom);
		add_op(OP_PUSH_FRONT, '0);
		add_op(OP_PUSH_BACK, -32'sd1);
		add_op(OP_UNUSED, 32'sh55aa55aa);
		add_op(OP_STATUS, 32'shaaaa5555);
		add_op(OP_POP_BACK, $urandom);
		add_op(OP_POP_FRONT, $urandom);
		add_op(OP_READ_BACK, $urandom);
		add_op(OP_POP_FRONT, $urandom);
		add_op(OP_POP_BACK, $urandom);
		add_op(OP_POP_BACK, $urandom);
		add_op(OP_READ_FRONT, $urandom);

		// Random: fill to full and past it, drain to empty and past it, and mixed runs.
		first_segment = 1'b1;
		while (pending_ops.size() < TARGET_OPS) begin
			kind = first_segment ? 0 : $urandom_range(0, 3);
			first_segment = 1'b0;
			if ($urandom_range(0, 3) == 0)
				gen_burst = ~gen_burst;
			case (kind)
				0: begin
					n = DEPTH - gen_count + $urandom_range(1, 3);
					repeat (n) add_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word());
				end
				1: begin
					n = gen_count + $urandom_range(1, 3);
					repeat (n) begin
						if ($urandom_range(0, 5) == 0)
							add_op($urandom_range(0, 1) ? OP_READ_BACK : OP_READ_FRONT, $urandom);
						add_op($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
					end
				end
				default: begin
					n = $urandom_range(20, 60);
					repeat (n) add_op(3'($urandom_range(0, 7)), pick_word());
				end
			endcase
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Sample at the falling edge so that the driver's updates have settled.
		while (pending_ops.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
